// ===== design/hill_splat_heightmap_accumulator_assert.svh =====
// ----------------------------------------------------------------------------
// Hill splat accumulator assertion macros
// Shared concurrent assertion forms, clocked and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef HILL_SPLAT_HEIGHTMAP_ACCUMULATOR_ASSERT_SVH
`define HILL_SPLAT_HEIGHTMAP_ACCUMULATOR_ASSERT_SVH

// same-cycle implication
`define HSHA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HSHA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/hsha_pkg.sv =====
// ----------------------------------------------------------------------------
// Hill splat accumulator package
// Field widths, operation codes, controller states and command/status types.
// ----------------------------------------------------------------------------
`default_nettype none

package hsha_pkg;

  // default structural parameters
  localparam int unsigned MAP_SIDE_DEF  = 256;
  localparam int unsigned CELL_BITS_DEF = 40;
  localparam int unsigned FRAC_BITS_DEF = 4;

  // request and response field widths
  localparam int unsigned OP_W       = 2;
  localparam int unsigned CENTER_W   = 14;
  localparam int unsigned RADIUS_W   = 12;
  localparam int unsigned CELL_IDX_W = 8;
  localparam int unsigned HEIGHT_W   = 40;

  // configuration registers
  localparam int unsigned DIM_W     = 9;
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [DIM_W-1:0]     DIM_RESET      = 9'd256;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 1'd1;

  typedef enum logic [OP_W-1:0] {
    OP_ADD_HILL  = 2'd0,
    OP_READ_CELL = 2'd1,
    OP_CLEAR_MAP = 2'd2
  } hsha_op_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_START,
    ST_WALK,
    ST_DRAIN,
    ST_READ,
    ST_RDWAIT,
    ST_CLEAR,
    ST_DONE
  } hsha_state_e;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic setup;
    logic walk_start;
    logic walk_step;
    logic sweep_step;
    logic read_issue;
    logic read_capture;
    logic out_load;
  } hsha_cmd_t;

  // datapath to controller
  typedef struct packed {
    hsha_op_e op;
    logic     box_empty;
    logic     walk_last;
    logic     pipe_busy;
    logic     sweep_last;
    logic     read_outside;
  } hsha_sts_t;

endpackage

`default_nettype wire

// ===== design/hsha_req_if.sv =====
// ----------------------------------------------------------------------------
// Hill splat request channel
// Valid/ready channel carrying one add, read or clear request.
// ----------------------------------------------------------------------------
`default_nettype none

interface hsha_req_if;
  logic                                     valid;
  logic                                     ready;
  logic        [hsha_pkg::OP_W-1:0]         operation;
  logic signed [hsha_pkg::CENTER_W-1:0]     center_x;
  logic signed [hsha_pkg::CENTER_W-1:0]     center_y;
  logic        [hsha_pkg::RADIUS_W-1:0]     hill_radius;
  logic        [hsha_pkg::CELL_IDX_W-1:0]   cell_col;
  logic        [hsha_pkg::CELL_IDX_W-1:0]   cell_row;

  modport source (
    output valid, operation, center_x, center_y, hill_radius, cell_col, cell_row,
    input  ready
  );

  modport sink (
    input  valid, operation, center_x, center_y, hill_radius, cell_col, cell_row,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/hsha_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Hill splat response channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface hsha_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [hsha_pkg::HEIGHT_W-1:0]     cell_height;
  logic                              op_status;

  modport source (
    output valid, cell_height, op_status,
    input  ready
  );

  modport sink (
    input  valid, cell_height, op_status,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/hill_splat_heightmap_accumulator.sv =====
// ----------------------------------------------------------------------------
// Hill splat heightmap accumulator
// Adds clipped paraboloid hills into a cleared heightmap, reads and clears it.
//
// Channel  Dir  Handshake    Carries
// req_i    in   valid/ready  operation, center_x, center_y, hill_radius,
//                            cell_col, cell_row
// rsp_o    out  valid/ready  cell_height, op_status
// cfg      in   cfg_we_i     cfg_idx_i, cfg_wdata_i (map_width, map_height)
//
// After reset the store is swept to zero, one cell a cycle, all MAP_SIDE*MAP_SIDE
// cells (65536 by default), with req_i.ready low.
// Add hill: one box cell a cycle through the four-stage read-modify-write
// pipeline on the store's read and write ports; an empty box writes nothing.
// Read: status set for a cell outside the map. Clear: full sweep of the store.
// A finished result sits in the response register, so the next request is taken
// while it waits; a stalled response holds the following result in done.
// ----------------------------------------------------------------------------
`default_nettype none

module hill_splat_heightmap_accumulator #(
  parameter int unsigned MAP_SIDE  = hsha_pkg::MAP_SIDE_DEF,
  parameter int unsigned CELL_BITS = hsha_pkg::CELL_BITS_DEF,
  parameter int unsigned FRAC_BITS = hsha_pkg::FRAC_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [hsha_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [hsha_pkg::DIM_W-1:0]     cfg_wdata_i,
  hsha_req_if.sink                            req_i,
  hsha_rsp_if.source                          rsp_o
);

  localparam int unsigned DEPTH  = MAP_SIDE * MAP_SIDE;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  hsha_pkg::hsha_cmd_t cmd;
  hsha_pkg::hsha_sts_t sts;
  logic                in_ready;
  logic                out_valid;

  logic                 ram_we, ram_re;
  logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
  logic [CELL_BITS-1:0] ram_wdata, ram_rdata;

  // sequencing
  hsha_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  assign req_i.ready = in_ready;
  assign rsp_o.valid = out_valid;

  // arithmetic, counters and result registers
  hsha_dp #(
    .MAP_SIDE  (MAP_SIDE),
    .CELL_BITS (CELL_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .operation_i   (req_i.operation),
    .center_x_i    (req_i.center_x),
    .center_y_i    (req_i.center_y),
    .hill_radius_i (req_i.hill_radius),
    .cell_col_i    (req_i.cell_col),
    .cell_row_i    (req_i.cell_row),
    .cell_height_o (rsp_o.cell_height),
    .op_status_o   (rsp_o.op_status),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_re_o      (ram_re),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata)
  );

  // height store
  hsha_ram #(
    .WIDTH (CELL_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

// ===== design/hsha_ram.sv =====
// ----------------------------------------------------------------------------
// Hill splat generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module hsha_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 65536
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/hsha_ctrl.sv =====
// ----------------------------------------------------------------------------
// Hill splat controller
// Sequences the clearing pass, hill walk, cell read and response hand-off.
// ----------------------------------------------------------------------------
`default_nettype none
`include "hill_splat_heightmap_accumulator_assert.svh"

module hsha_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  output      logic                out_valid_o,
  input  wire logic                out_ready_i,
  output      hsha_pkg::hsha_cmd_t cmd_o,
  input  wire hsha_pkg::hsha_sts_t sts_i
);

  hsha_pkg::hsha_state_e state_q, state_d;
  logic                  out_valid_q, out_valid_d;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hsha_pkg::ST_INIT: begin
        if (sts_i.sweep_last) state_d = hsha_pkg::ST_IDLE;
      end
      hsha_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = hsha_pkg::ST_DECODE;
      end
      hsha_pkg::ST_DECODE: begin
        unique case (sts_i.op)
          hsha_pkg::OP_ADD_HILL:  state_d = hsha_pkg::ST_START;
          hsha_pkg::OP_READ_CELL: state_d = hsha_pkg::ST_READ;
          hsha_pkg::OP_CLEAR_MAP: state_d = hsha_pkg::ST_CLEAR;
          default:                state_d = hsha_pkg::ST_DONE;
        endcase
      end
      hsha_pkg::ST_START: begin
        state_d = sts_i.box_empty ? hsha_pkg::ST_DONE : hsha_pkg::ST_WALK;
      end
      hsha_pkg::ST_WALK: begin
        if (sts_i.walk_last) state_d = hsha_pkg::ST_DRAIN;
      end
      hsha_pkg::ST_DRAIN: begin
        if (!sts_i.pipe_busy) state_d = hsha_pkg::ST_DONE;
      end
      hsha_pkg::ST_READ: begin
        state_d = sts_i.read_outside ? hsha_pkg::ST_DONE : hsha_pkg::ST_RDWAIT;
      end
      hsha_pkg::ST_RDWAIT: begin
        state_d = hsha_pkg::ST_DONE;
      end
      hsha_pkg::ST_CLEAR: begin
        if (sts_i.sweep_last) state_d = hsha_pkg::ST_DONE;
      end
      hsha_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) state_d = hsha_pkg::ST_IDLE;
      end
      default: state_d = hsha_pkg::ST_IDLE;
    endcase
  end

  // commands to the datapath
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      hsha_pkg::ST_INIT:   cmd_o.sweep_step = 1'b1;
      hsha_pkg::ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_item = in_valid_i;
      end
      hsha_pkg::ST_DECODE: cmd_o.setup = 1'b1;
      hsha_pkg::ST_START:  cmd_o.walk_start = !sts_i.box_empty;
      hsha_pkg::ST_WALK:   cmd_o.walk_step = 1'b1;
      hsha_pkg::ST_DRAIN:  cmd_o = '0;
      hsha_pkg::ST_READ:   cmd_o.read_issue = 1'b1;
      hsha_pkg::ST_RDWAIT: cmd_o.read_capture = 1'b1;
      hsha_pkg::ST_CLEAR:  cmd_o.sweep_step = 1'b1;
      hsha_pkg::ST_DONE:   cmd_o.out_load = !out_valid_q || out_ready_i;
      default:             cmd_o = '0;
    endcase
  end

  // response valid: set on hand-off, dropped once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hsha_pkg::ST_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `HSHA_ASSERT_NXT(a_accept_decodes, clk_i, rst_ni, in_valid_i && in_ready_o,
                   state_q == hsha_pkg::ST_DECODE, "accepted request not decoded")
  `HSHA_ASSERT_IMP(a_rsp_from_done, clk_i, rst_ni, $rose(out_valid_o),
                   $past(state_q == hsha_pkg::ST_DONE), "response raised outside done")
  `HSHA_ASSERT_IMP(a_walk_box, clk_i, rst_ni, cmd_o.walk_step, !sts_i.box_empty,
                   "walk stepped over an empty box")

endmodule

`default_nettype wire

// ===== design/hsha_dp.sv =====
// ----------------------------------------------------------------------------
// Hill splat datapath
// Request capture, box set-up, four-stage cell update pipeline, sweeps, result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "hill_splat_heightmap_accumulator_assert.svh"

module hsha_dp #(
  parameter int unsigned MAP_SIDE  = hsha_pkg::MAP_SIDE_DEF,
  parameter int unsigned CELL_BITS = hsha_pkg::CELL_BITS_DEF,
  parameter int unsigned FRAC_BITS = hsha_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire hsha_pkg::hsha_cmd_t                    cmd_i,
  output      hsha_pkg::hsha_sts_t                    sts_o,
  // configuration
  input  wire logic                                   cfg_we_i,
  input  wire logic        [hsha_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic        [hsha_pkg::DIM_W-1:0]      cfg_wdata_i,
  // request payload
  input  wire logic        [hsha_pkg::OP_W-1:0]       operation_i,
  input  wire logic signed [hsha_pkg::CENTER_W-1:0]   center_x_i,
  input  wire logic signed [hsha_pkg::CENTER_W-1:0]   center_y_i,
  input  wire logic        [hsha_pkg::RADIUS_W-1:0]   hill_radius_i,
  input  wire logic        [hsha_pkg::CELL_IDX_W-1:0] cell_col_i,
  input  wire logic        [hsha_pkg::CELL_IDX_W-1:0] cell_row_i,
  // response payload
  output      logic        [hsha_pkg::HEIGHT_W-1:0]   cell_height_o,
  output      logic                                   op_status_o,
  // height store
  output      logic                                   ram_we_o,
  output      logic [$clog2(MAP_SIDE*MAP_SIDE)-1:0]   ram_waddr_o,
  output      logic [CELL_BITS-1:0]                   ram_wdata_o,
  output      logic                                   ram_re_o,
  output      logic [$clog2(MAP_SIDE*MAP_SIDE)-1:0]   ram_raddr_o,
  input  wire logic [CELL_BITS-1:0]                   ram_rdata_i
);

  localparam int unsigned DEPTH    = MAP_SIDE * MAP_SIDE;
  localparam int unsigned ADDR_W   = $clog2(DEPTH);
  localparam int unsigned COORD_W  = $clog2(MAP_SIDE + 1);
  localparam int unsigned POS_W    = COORD_W + FRAC_BITS;
  localparam int unsigned CENTER_W = hsha_pkg::CENTER_W;
  localparam int unsigned RADIUS_W = hsha_pkg::RADIUS_W;
  localparam int unsigned OFF_W    = ((POS_W > CENTER_W) ? POS_W : CENTER_W) + 2;
  localparam int unsigned SQ_W     = 2 * OFF_W;
  localparam int unsigned R2_W     = 2 * RADIUS_W;
  localparam int unsigned V_W      = ((SQ_W > R2_W) ? SQ_W : R2_W) + 2;
  localparam int unsigned BOX_W    = CENTER_W + 2;
  localparam logic signed [BOX_W-1:0] ONE_FX = BOX_W'(1) <<< FRAC_BITS;
  localparam logic [CELL_BITS-1:0]    CELL_MAX = '1;

  // configuration registers
  logic [hsha_pkg::DIM_W-1:0] map_width_q, map_height_q;

  // request registers
  hsha_pkg::hsha_op_e                     op_q;
  logic signed [CENTER_W-1:0]             cx_q, cy_q;
  logic        [RADIUS_W-1:0]             rad_q;
  logic        [hsha_pkg::CELL_IDX_W-1:0] rd_col_q, rd_row_q;

  // box and walk counters
  logic [COORD_W-1:0] lo_x_q, hi_x_q, lo_y_q, hi_y_q;
  logic [COORD_W-1:0] wcol_q, wrow_q;
  logic               box_empty_q;
  logic [R2_W-1:0]    r2_q;

  // pipeline
  logic                    s1_valid_q, s2_valid_q, s3_valid_q;
  logic signed [OFF_W-1:0] s1_dx_q, s1_dy_q;
  logic [ADDR_W-1:0]       s1_addr_q, s2_addr_q, s3_addr_q;
  logic [SQ_W-1:0]         s2_dx2_q, s2_dy2_q;
  logic [R2_W-1:0]         s3_v_q;
  logic                    s3_pos_q;

  // sweep, result and response registers
  logic [ADDR_W-1:0]             sweep_q;
  logic [hsha_pkg::HEIGHT_W-1:0] res_height_q, out_height_q;
  logic                          res_status_q, out_status_q;

  // effective map size
  logic [COORD_W-1:0] eff_w, eff_h;
  assign eff_w = (32'(map_width_q) > MAP_SIDE) ? COORD_W'(MAP_SIDE) : COORD_W'(map_width_q);
  assign eff_h = (32'(map_height_q) > MAP_SIDE) ? COORD_W'(MAP_SIDE) : COORD_W'(map_height_q);

  // clipped box per axis
  logic signed [BOX_W-1:0] cxe, cye, rade, size_w, size_h;
  logic signed [BOX_W-1:0] ax, bx, ay, by, lo_x, hi_x, lo_y, hi_y;
  assign cxe    = BOX_W'(cx_q);
  assign cye    = BOX_W'(cy_q);
  assign rade   = $signed(BOX_W'(rad_q));
  assign size_w = $signed(BOX_W'(eff_w));
  assign size_h = $signed(BOX_W'(eff_h));
  assign ax     = (cxe - rade - ONE_FX) >>> FRAC_BITS;
  assign bx     = (cxe + rade + ONE_FX) >>> FRAC_BITS;
  assign ay     = (cye - rade - ONE_FX) >>> FRAC_BITS;
  assign by     = (cye + rade + ONE_FX) >>> FRAC_BITS;
  assign lo_x   = (ax < 0) ? '0 : ax;
  assign hi_x   = (bx > size_w) ? size_w : bx;
  assign lo_y   = (ay < 0) ? '0 : ay;
  assign hi_y   = (by > size_h) ? size_h : by;

  // walk order: columns inner, rows outer
  logic col_last;
  assign col_last = (wcol_q == hi_x_q - 1'b1);

  // stage 0 offsets and address
  logic signed [OFF_W-1:0] dx0, dy0;
  logic [ADDR_W-1:0]       addr0;
  assign dx0   = OFF_W'(cx_q) - $signed(OFF_W'(wcol_q) << FRAC_BITS);
  assign dy0   = OFF_W'(cy_q) - $signed(OFF_W'(wrow_q) << FRAC_BITS);
  assign addr0 = ADDR_W'(32'(wrow_q) * MAP_SIDE + 32'(wcol_q));

  // stage 1 squares
  logic signed [SQ_W-1:0] dx2, dy2;
  assign dx2 = SQ_W'(s1_dx_q) * SQ_W'(s1_dx_q);
  assign dy2 = SQ_W'(s1_dy_q) * SQ_W'(s1_dy_q);

  // stage 2 hill value
  logic signed [V_W-1:0] v2;
  assign v2 = $signed(V_W'(r2_q)) - $signed(V_W'(s2_dx2_q)) - $signed(V_W'(s2_dy2_q));

  // stage 3 saturating add
  logic [CELL_BITS:0]    sum3;
  logic [CELL_BITS-1:0]  upd3;
  assign sum3 = {1'b0, ram_rdata_i} + (CELL_BITS+1)'(s3_v_q);
  assign upd3 = sum3[CELL_BITS] ? CELL_MAX : sum3[CELL_BITS-1:0];

  // read request address and range check
  logic              read_outside;
  logic [ADDR_W-1:0] rd_addr;
  assign read_outside = (32'(rd_col_q) >= 32'(eff_w)) || (32'(rd_row_q) >= 32'(eff_h));
  assign rd_addr      = ADDR_W'(32'(rd_row_q) * MAP_SIDE + 32'(rd_col_q));

  // store port selection
  always_comb begin
    ram_we_o    = 1'b0;
    ram_waddr_o = s3_addr_q;
    ram_wdata_o = upd3;
    if (cmd_i.sweep_step) begin
      ram_we_o    = 1'b1;
      ram_waddr_o = sweep_q;
      ram_wdata_o = '0;
    end else if (s3_valid_q && s3_pos_q) begin
      ram_we_o = 1'b1;
    end
    ram_re_o    = s2_valid_q || (cmd_i.read_issue && !read_outside);
    ram_raddr_o = s2_valid_q ? s2_addr_q : rd_addr;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q  <= hsha_pkg::DIM_RESET;
      map_height_q <= hsha_pkg::DIM_RESET;
      s1_valid_q   <= 1'b0;
      s2_valid_q   <= 1'b0;
      s3_valid_q   <= 1'b0;
      sweep_q      <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i == hsha_pkg::CFG_MAP_WIDTH) begin
        map_width_q <= cfg_wdata_i;
      end
      if (cfg_we_i && cfg_idx_i == hsha_pkg::CFG_MAP_HEIGHT) begin
        map_height_q <= cfg_wdata_i;
      end
      s1_valid_q <= cmd_i.walk_step;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      if (cmd_i.sweep_step) begin
        sweep_q <= (sweep_q == ADDR_W'(DEPTH - 1)) ? '0 : sweep_q + 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q         <= hsha_pkg::hsha_op_e'(operation_i);
      cx_q         <= center_x_i;
      cy_q         <= center_y_i;
      rad_q        <= hill_radius_i;
      rd_col_q     <= cell_col_i;
      rd_row_q     <= cell_row_i;
      res_height_q <= '0;
      res_status_q <= 1'b0;
    end
    if (cmd_i.setup) begin
      lo_x_q      <= lo_x[COORD_W-1:0];
      hi_x_q      <= hi_x[COORD_W-1:0];
      lo_y_q      <= lo_y[COORD_W-1:0];
      hi_y_q      <= hi_y[COORD_W-1:0];
      box_empty_q <= (lo_x >= hi_x) || (lo_y >= hi_y);
      r2_q        <= R2_W'(rad_q) * R2_W'(rad_q);
    end
    if (cmd_i.walk_start) begin
      wcol_q <= lo_x_q;
      wrow_q <= lo_y_q;
    end else if (cmd_i.walk_step) begin
      wcol_q <= col_last ? lo_x_q : wcol_q + 1'b1;
      wrow_q <= col_last ? wrow_q + 1'b1 : wrow_q;
    end
    // update pipeline
    s1_dx_q   <= dx0;
    s1_dy_q   <= dy0;
    s1_addr_q <= addr0;
    s2_dx2_q  <= dx2;
    s2_dy2_q  <= dy2;
    s2_addr_q <= s1_addr_q;
    s3_v_q    <= v2[R2_W-1:0];
    s3_pos_q  <= (v2 > 0);
    s3_addr_q <= s2_addr_q;
    // result
    if (cmd_i.read_issue) begin
      res_status_q <= read_outside;
    end
    if (cmd_i.read_capture) begin
      res_height_q <= hsha_pkg::HEIGHT_W'(ram_rdata_i);
    end
    if (cmd_i.out_load) begin
      out_height_q <= res_height_q;
      out_status_q <= res_status_q;
    end
  end

  assign sts_o.op           = op_q;
  assign sts_o.box_empty    = box_empty_q;
  assign sts_o.walk_last    = col_last && (wrow_q == hi_y_q - 1'b1);
  assign sts_o.pipe_busy    = s1_valid_q || s2_valid_q || s3_valid_q;
  assign sts_o.sweep_last   = (sweep_q == ADDR_W'(DEPTH - 1));
  assign sts_o.read_outside = read_outside;

  assign cell_height_o = out_height_q;
  assign op_status_o   = out_status_q;

  `HSHA_ASSERT_IMP(a_hill_no_decrease, clk_i, rst_ni, s3_valid_q && s3_pos_q,
                   ram_wdata_o >= ram_rdata_i, "hill update lowered a cell")

endmodule

`default_nettype wire
